@@ rtl/tcy_pkg.sv @@
package tcy_pkg;

   localparam int STAGE_LIMIT = 24;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_FIELD_X = 2'd0,
      CSR_REF_FIELD_Y = 2'd1,
      CSR_REF_FIELD_Z = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   localparam logic signed [15:0] REF_FIELD_X_RESET = -16'sd6639;
   localparam logic signed [15:0] REF_FIELD_Y_RESET = 16'sd1186;
   localparam logic signed [15:0] REF_FIELD_Z_RESET = 16'sd214;

   // arctan(2^-i), 2^32 = full circle
   localparam logic [31:0] ATAN_TAB [STAGE_LIMIT] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } ref_field_type;

endpackage

@@ rtl/tcy_sincos.sv @@
module tcy_sincos #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [15:0] angle,
   output logic signed [15:0] sin_q14,
   output logic signed [15:0] cos_q14
);
   import tcy_pkg::*;

   localparam int W = 34;

   logic signed [W-1:0] x_ff [STAGES+1];
   logic signed [W-1:0] y_ff [STAGES+1];
   logic signed [W-1:0] z_ff [STAGES+1];
   logic                flip_ff [STAGES+1];
   logic signed [15:0]  sin_ff, cos_ff;
   logic signed [15:0]  sin_in, cos_in;

   // fold the angle into the right half plane; negate the result later
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= W'(CORDIC_GAIN_Q30);
         y_ff[0]    <= '0;
         z_ff[0]    <= W'($signed({angle[14], angle[14:0], 16'h0000}));
         flip_ff[0] <= angle[15] ^ angle[14];
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed(W'(ATAN_TAB[i]));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed(W'(ATAN_TAB[i]));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [W-1:0] xf, yf, xr, yr;
      xf = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      yf = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
      xr = (xf + W'(32768)) >>> 16;
      yr = (yf + W'(32768)) >>> 16;
      priority if (xr > W'(Q14_ONE))  cos_in = Q14_ONE;
      else if (xr < -W'(Q14_ONE))     cos_in = -Q14_ONE;
      else                            cos_in = xr[15:0];
      priority if (yr > W'(Q14_ONE))  sin_in = Q14_ONE;
      else if (yr < -W'(Q14_ONE))     sin_in = -Q14_ONE;
      else                            sin_in = yr[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q14 = sin_ff;
   assign cos_q14 = cos_ff;

endmodule

@@ rtl/tcy_solve.sv @@
module tcy_solve (
   input  logic                   clock,
   input  logic                   adv,
   input  tcy_pkg::ref_field_type ref_field,
   input  logic signed [15:0]     sa,
   input  logic signed [15:0]     ca,
   input  logic signed [15:0]     sb,
   input  logic signed [15:0]     cb,
   input  logic signed [15:0]     mag_x,
   input  logic signed [15:0]     mag_y,
   output logic signed [63:0]     num_s,
   output logic signed [63:0]     num_c,
   output logic signed [63:0]     det
);
   import tcy_pkg::*;

   logic signed [15:0] sasb_ff, sacb_ff, ca1_ff, sb1_ff, cb1_ff, mgx1_ff, mgy1_ff;
   logic signed [31:0] sasb_in, sacb_in;
   logic signed [31:0] a1_ff, b1_ff, c1_ff, a2_ff, b2_ff, c2_ff;
   logic signed [63:0] p_a2c1_ff, p_a1c2_ff, p_b2c1_ff, p_b1c2_ff, p_a2b1_ff, p_a1b2_ff;
   logic signed [63:0] num_s_ff, num_c_ff, det_ff;

   assign sasb_in = (32'(sa) * 32'(sb) + 32'sd8192) >>> 14;
   assign sacb_in = (32'(sa) * 32'(cb) + 32'sd8192) >>> 14;

   always_ff @(posedge clock) begin
      if (adv) begin
         sasb_ff <= sasb_in[15:0];
         sacb_ff <= sacb_in[15:0];
         ca1_ff  <= ca;
         sb1_ff  <= sb;
         cb1_ff  <= cb;
         mgx1_ff <= mag_x;
         mgy1_ff <= mag_y;
      end
   end

   // coefficients of the 2x2 system, Q14
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= 32'(ref_field.x) * 32'(cb1_ff);
         b1_ff <= 32'(ref_field.y) * 32'(cb1_ff);
         c1_ff <= (32'(mgx1_ff) <<< 14) + 32'(ref_field.z) * 32'(sb1_ff);
         a2_ff <= 32'(ref_field.x) * 32'(sasb_ff) + 32'(ref_field.y) * 32'(ca1_ff);
         b2_ff <= 32'(ref_field.y) * 32'(sasb_ff) - 32'(ref_field.x) * 32'(ca1_ff);
         c2_ff <= (32'(mgy1_ff) <<< 14) - 32'(ref_field.z) * 32'(sacb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_a2c1_ff <= 64'(a2_ff) * 64'(c1_ff);
         p_a1c2_ff <= 64'(a1_ff) * 64'(c2_ff);
         p_b2c1_ff <= 64'(b2_ff) * 64'(c1_ff);
         p_b1c2_ff <= 64'(b1_ff) * 64'(c2_ff);
         p_a2b1_ff <= 64'(a2_ff) * 64'(b1_ff);
         p_a1b2_ff <= 64'(a1_ff) * 64'(b2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_s_ff <= p_a2c1_ff - p_a1c2_ff;
         num_c_ff <= p_b2c1_ff - p_b1c2_ff;
         det_ff   <= p_a2b1_ff - p_a1b2_ff;
      end
   end

   assign num_s = num_s_ff;
   assign num_c = num_c_ff;
   assign det   = det_ff;

endmodule

@@ rtl/tcy_atan.sv @@
module tcy_atan #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [63:0] num_s,
   input  logic signed [63:0] num_c,
   input  logic signed [63:0] det,
   output logic signed [15:0] yaw,
   output logic               degenerate
);
   import tcy_pkg::*;

   localparam logic signed [63:0] BIG_LIMIT = 64'sd1 <<< 58;

   logic signed [63:0] py_ff, px_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic               degen0_ff, zero0_ff, degen1_ff, zero1_ff, half1_ff;
   logic               degen2_ff, zero2_ff, half2_ff, big2_ff;
   logic [5:0]         k2_ff;
   logic signed [63:0] x_ff [STAGES+1];
   logic signed [63:0] y_ff [STAGES+1];
   logic [31:0]        z_ff [STAGES+1];
   logic               degen_ff [STAGES+1];
   logic               zero_ff  [STAGES+1];
   logic signed [15:0] yaw_ff;
   logic               degen_out_ff;
   logic signed [63:0] ay, m;
   logic [5:0]         msb, k_in;
   logic [31:0]        zr;

   // fix signs by the determinant so no divide is needed
   always_ff @(posedge clock) begin
      if (adv) begin
         py_ff     <= (det > 0) ? num_s : -num_s;
         px_ff     <= (det > 0) ? -num_c : num_c;
         degen0_ff <= (det == 0);
         zero0_ff  <= (num_s == 0) && (num_c == 0);
      end
   end

   // turn by pi into the right half plane
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff     <= (px_ff < 0) ? -px_ff : px_ff;
         y1_ff     <= (px_ff < 0) ? -py_ff : py_ff;
         half1_ff  <= (px_ff < 0);
         degen1_ff <= degen0_ff;
         zero1_ff  <= zero0_ff;
      end
   end

   always_comb begin
      ay  = (y1_ff < 0) ? -y1_ff : y1_ff;
      m   = (x1_ff > ay) ? x1_ff : ay;
      msb = 6'd57;
      for (int b = 0; b < 57; b++) begin
         if (m[b]) msb = 6'(b);
      end
      for (int b = 57; b < 58; b++) begin
         if (m[b]) msb = 6'(b);
      end
      k_in = 6'd57 - msb;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         big2_ff   <= (m >= BIG_LIMIT);
         k2_ff     <= k_in;
         half2_ff  <= half1_ff;
         degen2_ff <= degen1_ff;
         zero2_ff  <= zero1_ff;
      end
   end

   // normalize the larger magnitude into [2^57, 2^58), or shift both right by 3 when it is 2^58 or more
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]     <= big2_ff ? (x2_ff >>> 3) : (x2_ff <<< k2_ff);
         y_ff[0]     <= big2_ff ? (y2_ff >>> 3) : (y2_ff <<< k2_ff);
         z_ff[0]     <= {half2_ff, 31'd0};
         degen_ff[0] <= degen2_ff;
         zero_ff[0]  <= zero2_ff;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
            end
            degen_ff[i+1] <= degen_ff[i];
            zero_ff[i+1]  <= zero_ff[i];
         end
      end
   end

   assign zr = z_ff[STAGES] + 32'h0000_8000;

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_ff       <= (degen_ff[STAGES] || zero_ff[STAGES]) ? '0 : $signed(zr[31:16]);
         degen_out_ff <= degen_ff[STAGES];
      end
   end

   assign yaw        = yaw_ff;
   assign degenerate = degen_out_ff;

endmodule

@@ rtl/tilt_compensated_yaw_solver.sv @@
// Tilt-compensated yaw solver. Each transfer carries roll, pitch and body x/y
// field; the result is yaw as a 16-bit binary angle (pi = 32768), forced to 0
// with degenerate set when the system determinant is zero, and to 0 when both
// numerators are zero. One item is taken every cycle; the pipeline is the two
// CORDIC chains (one register per iteration, STAGES = min(CORDIC_STAGES, 24))
// plus the multiplier and normalize stages. The whole pipeline holds while a
// result waits untaken. Write the reference field only while the block is idle.
module tilt_compensated_yaw_solver #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [15:0]              req_roll_angle,
   input  logic signed [15:0]              req_pitch_angle,
   input  logic signed [15:0]              req_mag_body_x,
   input  logic signed [15:0]              req_mag_body_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [15:0]              rsp_yaw_angle,
   output logic                            rsp_degenerate,
   input  logic                            csr_write_en,
   input  logic [tcy_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);
   import tcy_pkg::*;

   localparam int STAGES = (CORDIC_STAGES > STAGE_LIMIT) ? STAGE_LIMIT : CORDIC_STAGES;
   localparam int SC_LAT = STAGES + 2;
   localparam int LATENCY = 2 * STAGES + 11;

   logic                adv;
   logic [LATENCY-1:0]  valid_ff, valid_in;
   ref_field_type       ref_ff;
   logic signed [15:0]  mgx_ff [SC_LAT];
   logic signed [15:0]  mgy_ff [SC_LAT];
   logic signed [15:0]  sa, ca, sb, cb;
   logic signed [63:0]  num_s, num_c, det;

   // advance everything whenever the output slot is free
   assign adv       = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[LATENCY-1];
   assign valid_in  = {valid_ff[LATENCY-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff.x <= REF_FIELD_X_RESET;
         ref_ff.y <= REF_FIELD_Y_RESET;
         ref_ff.z <= REF_FIELD_Z_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_FIELD_X: ref_ff.x <= $signed(csr_wdata);
            CSR_REF_FIELD_Y: ref_ff.y <= $signed(csr_wdata);
            CSR_REF_FIELD_Z: ref_ff.z <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // delay the body field to meet the sine/cosine results
   always_ff @(posedge clock) begin
      if (adv) begin
         mgx_ff[0] <= req_mag_body_x;
         mgy_ff[0] <= req_mag_body_y;
         for (int i = 1; i < SC_LAT; i++) begin
            mgx_ff[i] <= mgx_ff[i-1];
            mgy_ff[i] <= mgy_ff[i-1];
         end
      end
   end

   tcy_sincos #(.STAGES(STAGES)) u_roll (
      .clock(clock), .adv(adv), .angle(req_roll_angle), .sin_q14(sa), .cos_q14(ca)
   );

   tcy_sincos #(.STAGES(STAGES)) u_pitch (
      .clock(clock), .adv(adv), .angle(req_pitch_angle), .sin_q14(sb), .cos_q14(cb)
   );

   tcy_solve u_solve (
      .clock(clock), .adv(adv), .ref_field(ref_ff),
      .sa(sa), .ca(ca), .sb(sb), .cb(cb),
      .mag_x(mgx_ff[SC_LAT-1]), .mag_y(mgy_ff[SC_LAT-1]),
      .num_s(num_s), .num_c(num_c), .det(det)
   );

   tcy_atan #(.STAGES(STAGES)) u_atan (
      .clock(clock), .adv(adv), .num_s(num_s), .num_c(num_c), .det(det),
      .yaw(rsp_yaw_angle), .degenerate(rsp_degenerate)
   );

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_yaw_angle == 16'sd0)
      else $error("degenerate result with nonzero yaw");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> valid_ff == $past(valid_ff))
      else $error("pipeline valid bits moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ tb/yaw_checker.sv @@
module yaw_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic signed [15:0]              req_roll_angle,
   input  logic signed [15:0]              req_pitch_angle,
   input  logic signed [15:0]              req_mag_body_x,
   input  logic signed [15:0]              req_mag_body_y,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic signed [15:0]              rsp_yaw_angle,
   input  logic                            rsp_degenerate,
   input  logic                            csr_write_en,
   input  logic [tcy_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata,
   output int                              fail_count,
   output int                              heading_backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcy_pkg::*;

   localparam int STAGES = (CORDIC_STAGES > STAGE_LIMIT) ? STAGE_LIMIT : CORDIC_STAGES;

   typedef struct {
      logic signed [15:0] yaw;
      logic               degenerate;
   } heading_type;

   heading_type   heading_queue[$];
   ref_field_type field;

   function automatic longint clamp_q14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic void rotate_angle(input logic [15:0] ang,
                                        output longint s, output longint c);
      logic [31:0] th;
      logic        flip;
      int          th_signed;
      longint      z, x, y, nx;
      th = {ang, 16'd0};
      flip = th[31] ^ th[30];
      if (flip) th[31] = ~th[31];
      th_signed = th;
      z = th_signed;
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_q14((x + 32768) >>> 16);
      s = clamp_q14((y + 32768) >>> 16);
   endfunction

   function automatic logic [15:0] vector_angle(longint y, longint x);
      longint z, ay, m, nx, rounded;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd2147483648;
      end
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      if (m >= (64'sd1 <<< 58)) begin
         x = x >>> 3;
         y = y >>> 3;
      end else begin
         while (m < (64'sd1 <<< 57)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      rounded = (z + 32768) >>> 16;
      return rounded[15:0];
   endfunction

   function automatic heading_type solve_heading(logic signed [15:0] roll,
                                                 logic signed [15:0] pitch,
                                                 logic signed [15:0] mag_x,
                                                 logic signed [15:0] mag_y);
      heading_type h;
      longint      mx, my, mz, sa, ca, sb, cb, sasb, sacb;
      longint      a1, b1, c1, a2, b2, c2, num_s, num_c, det, py, px;
      mx = field.x;
      my = field.y;
      mz = field.z;
      rotate_angle(roll, sa, ca);
      rotate_angle(pitch, sb, cb);
      sasb = (sa * sb + 8192) >>> 14;
      sacb = (sa * cb + 8192) >>> 14;
      a1 = mx * cb;
      b1 = my * cb;
      c1 = longint'(mag_x) * 16384 + mz * sb;
      a2 = mx * sasb + my * ca;
      b2 = -mx * ca + my * sasb;
      c2 = longint'(mag_y) * 16384 - mz * sacb;
      num_s = a2 * c1 - a1 * c2;
      num_c = b2 * c1 - b1 * c2;
      det = a2 * b1 - a1 * b2;
      h.yaw = '0;
      h.degenerate = (det == 0);
      if (det != 0) begin
         if (det > 0) begin
            py = num_s;
            px = -num_c;
         end else begin
            py = -num_s;
            px = num_c;
         end
         if (px != 0 || py != 0) h.yaw = vector_angle(py, px);
      end
      return h;
   endfunction

   assign heading_backlog = heading_queue.size();

   always @(posedge clock) begin
      heading_type exp_h;
      if (reset) begin
         field.x <= REF_FIELD_X_RESET;
         field.y <= REF_FIELD_Y_RESET;
         field.z <= REF_FIELD_Z_RESET;
         heading_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_REF_FIELD_X: field.x <= csr_wdata;
               CSR_REF_FIELD_Y: field.y <= csr_wdata;
               CSR_REF_FIELD_Z: field.z <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            heading_queue.push_back(solve_heading(req_roll_angle, req_pitch_angle,
                                                  req_mag_body_x, req_mag_body_y));
         if (rsp_valid && rsp_ready) begin
            if (heading_queue.size() == 0) begin
               $error("unexpected result transfer: yaw_angle %0d degenerate %0d",
                      rsp_yaw_angle, rsp_degenerate);
               fail_count <= fail_count + 1;
            end else begin
               exp_h = heading_queue.pop_front();
               if (rsp_yaw_angle !== exp_h.yaw || rsp_degenerate !== exp_h.degenerate)
                  fail_count <= fail_count + 1;
               if (rsp_yaw_angle !== exp_h.yaw)
                  $error("yaw_angle: expected %0d actual %0d", exp_h.yaw, rsp_yaw_angle);
               if (rsp_degenerate !== exp_h.degenerate)
                  $error("degenerate: expected %0d actual %0d",
                         exp_h.degenerate, rsp_degenerate);
            end
         end
      end
   end
endmodule

@@ tb/tb_tilt_compensated_yaw_solver.sv @@
module tb_tilt_compensated_yaw_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import tcy_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = 2 * STAGES + 11;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_ready;
   logic signed [15:0]     req_roll_angle = '0;
   logic signed [15:0]     req_pitch_angle = '0;
   logic signed [15:0]     req_mag_body_x = '0;
   logic signed [15:0]     req_mag_body_y = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 0;
   logic signed [15:0]     rsp_yaw_angle;
   logic                   rsp_degenerate;
   logic                   csr_write_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REF_FIELD_X;
   logic [15:0]            csr_wdata = '0;
   int                     fail_count;
   int                     heading_backlog;

   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   tilt_compensated_yaw_solver #(.CORDIC_STAGES(STAGES)) DUT (.*);

   yaw_checker #(.CORDIC_STAGES(STAGES)) checker_i (.*);

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1;
         hold_left = LONG_HOLD;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_sample(logic [15:0] roll, logic [15:0] pitch,
                              logic [15:0] mag_x, logic [15:0] mag_y);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_roll_angle <= roll;
      req_pitch_angle <= pitch;
      req_mag_body_x <= mag_x;
      req_mag_body_y <= mag_y;
      // ready is stable from the falling edge on; the transfer lands on the next rise
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
   endtask

   // drop the enable again after each write so back-to-back writes stay apart
   task automatic write_field(csr_index_type idx, logic [15:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (heading_backlog != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] random_field();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(8191) - 4096);
         2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(32767) - 16384);
      endcase
   endfunction

   task automatic random_samples(int count);
      for (int n = 0; n < count; n++)
         send_sample(16'($urandom), 16'($urandom), random_field(), random_field());
   endtask

   initial begin
      logic [15:0] angles [6] = '{16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h7fff, 16'h2000};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: angle extremes, field extremes, zero body field
      for (int i = 0; i < 6; i++)
         send_sample(angles[i], angles[5 - i], 16'h7fff, 16'h8000);
      send_sample(16'h1234, 16'hedcb, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'hffff, 16'h0001, 16'hffff, 16'h0001);
      drain();

      // zero reference x and y: determinant vanishes
      write_field(CSR_REF_FIELD_X, 16'h0000);
      write_field(CSR_REF_FIELD_Y, 16'h0000);
      send_sample(16'h1000, 16'h2000, 16'h0100, 16'hff00);
      send_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      drain();

      // zero z and zero body field: both numerators vanish
      write_field(CSR_REF_FIELD_X, 16'h1000);
      write_field(CSR_REF_FIELD_Y, 16'hf800);
      write_field(CSR_REF_FIELD_Z, 16'h0000);
      send_sample(16'h0800, 16'hf000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // unused index must be dropped
      drain();
      write_field(CSR_UNUSED, 16'h5555);
      send_sample(16'h0800, 16'hf000, 16'h0000, 16'h0000);
      drain();

      // random phases over several reference settings and idle and stall mixes
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_field(CSR_REF_FIELD_X, REF_FIELD_X_RESET);
               write_field(CSR_REF_FIELD_Y, REF_FIELD_Y_RESET);
               write_field(CSR_REF_FIELD_Z, REF_FIELD_Z_RESET);
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               write_field(CSR_REF_FIELD_X, 16'h7fff);
               write_field(CSR_REF_FIELD_Y, 16'h8000);
               write_field(CSR_REF_FIELD_Z, 16'h7fff);
               idle_pct = 58;
               stall_pct = 0;
            end
            2: begin
               write_field(CSR_REF_FIELD_X, 16'h8000);
               write_field(CSR_REF_FIELD_Y, 16'h7fff);
               write_field(CSR_REF_FIELD_Z, 16'h8000);
               idle_pct = 0;
               stall_pct = 58;
            end
            3: begin
               write_field(CSR_REF_FIELD_X, random_field());
               write_field(CSR_REF_FIELD_Y, random_field());
               write_field(CSR_REF_FIELD_Z, random_field());
               idle_pct = 21;
               stall_pct = 21;
            end
            4: begin
               write_field(CSR_REF_FIELD_X, 16'h0000);
               write_field(CSR_REF_FIELD_Y, 16'h0000);
               idle_pct = 0;
               stall_pct = 0;
               hold_request = 1;
            end
            default: begin
               write_field(CSR_REF_FIELD_X, 16'($urandom));
               write_field(CSR_REF_FIELD_Y, 16'($urandom));
               write_field(CSR_REF_FIELD_Z, 16'($urandom));
               idle_pct = 21;
               stall_pct = 21;
            end
         endcase
         random_samples(100);
         drain();
      end

      if (fail_count == 0 && heading_backlog == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ tilt_compensated_yaw_solver.f @@
rtl/tcy_pkg.sv
rtl/tcy_sincos.sv
rtl/tcy_solve.sv
rtl/tcy_atan.sv
rtl/tilt_compensated_yaw_solver.sv
tb/yaw_checker.sv
tb/tb_tilt_compensated_yaw_solver.sv
